// ===== rtl/cluster_statistic_reducer_core_defines.svh =====
// Assertion macros shared by the cluster statistic reducer RTL.
// Needs signals named clk and rst in the module that uses them.
`ifndef CLUSTER_STATISTIC_REDUCER_CORE_DEFINES_SVH
`define CLUSTER_STATISTIC_REDUCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// invariant checked at every clock edge out of reset
`define CLSTAT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition in one cycle implies a consequence in the next
`define CLSTAT_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);
`else
`define CLSTAT_ASSERT(label, prop, msg)
`define CLSTAT_ASSERT_NEXT(label, cond, cons, msg)
`endif

`endif

// ===== rtl/clstat_pkg.sv =====
// Package for the cluster statistic reducer: types, codes and limits.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package clstat_pkg;

  localparam int unsigned MAG_W   = 32;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned NUM_W   = 16;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned SCALE_W = 32;
  localparam int unsigned PROD_W  = CNT_W + SCALE_W;

  localparam int unsigned MAX_CLUSTER_VOXELS = 65536;
  localparam int unsigned MAX_CLUSTERS       = 65535;

  localparam logic [MAG_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [MAG_W-1:0] Q_MIN = 32'h8000_0000;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd65536;

  typedef enum logic [MODE_W-1:0] {
    MODE_MEAN       = 3'd0,
    MODE_MAX        = 3'd1,
    MODE_ABS_MAX    = 3'd2,
    MODE_SIGNED_MAX = 3'd3,
    MODE_SIZE       = 3'd4,
    MODE_ORDER      = 3'd5
  } mode_t;

  typedef enum logic {
    REG_EDIT_MODE    = 1'b0,
    REG_VOLUME_SCALE = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic [MODE_W-1:0]  edit_mode;
    logic [SCALE_W-1:0] volume_scale;
  } cfg_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic signed [MAG_W-1:0] max_val;
    logic        [MAG_W-1:0] abs_max;
    logic signed [MAG_W-1:0] signed_max;
    logic        [CNT_W-1:0] count;
    logic        [NUM_W-1:0] number;
  } cluster_rec_t;

endpackage

`default_nettype wire

// ===== rtl/clstat_front.sv =====
// Front end: accepts voxel beats and accumulates per-cluster statistics.
// Emits one cluster record per cluster end. Uses clstat_pkg.
`default_nettype none

module clstat_front import clstat_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    accept,
  input  wire logic signed [MAG_W-1:0] magnitude,
  input  wire logic                    last_of_cluster,
  input  wire logic                    last_of_array,
  output logic                         rec_write,
  output cluster_rec_t                 rec
);

  localparam logic [CNT_W-1:0] VOX_LIMIT = CNT_W'(MAX_CLUSTER_VOXELS);
  localparam logic [NUM_W-1:0] NUM_LIMIT = NUM_W'(MAX_CLUSTERS);

  logic signed [SUM_W-1:0] run_sum, sum_next;
  logic signed [MAG_W-1:0] run_max, max_next;
  logic        [MAG_W-1:0] run_abs, abs_next;
  logic signed [MAG_W-1:0] run_smax, smax_next;
  logic        [CNT_W-1:0] voxel_counter, count_next;
  logic        [NUM_W-1:0] cluster_counter, number_next;

  logic [MAG_W-1:0] mag_u, mag_abs, smax_u, smax_abs;

  always_comb begin
    mag_u    = magnitude;
    mag_abs  = mag_u[MAG_W-1] ? (~mag_u + 1'b1) : mag_u;
    smax_u   = run_smax;
    smax_abs = smax_u[MAG_W-1] ? (~smax_u + 1'b1) : smax_u;

    sum_next   = run_sum;
    max_next   = run_max;
    abs_next   = run_abs;
    smax_next  = run_smax;
    count_next = voxel_counter;

    if (voxel_counter == '0) begin
      sum_next   = {{(SUM_W-MAG_W){magnitude[MAG_W-1]}}, magnitude};
      max_next   = magnitude;
      abs_next   = mag_abs;
      smax_next  = magnitude;
      count_next = CNT_W'(1);
    end else if (voxel_counter < VOX_LIMIT) begin
      sum_next = run_sum + {{(SUM_W-MAG_W){magnitude[MAG_W-1]}}, magnitude};
      if (magnitude > run_max) max_next = magnitude;
      if (mag_abs > run_abs) abs_next = mag_abs;
      if (mag_abs > smax_abs) smax_next = magnitude;
      count_next = voxel_counter + 1'b1;
    end
    // beats past the voxel limit are dropped but may still close the cluster

    number_next = (cluster_counter < NUM_LIMIT) ? cluster_counter + 1'b1 : cluster_counter;
  end

  assign rec_write = accept && last_of_cluster;

  always_comb begin
    rec.sum        = sum_next;
    rec.max_val    = max_next;
    rec.abs_max    = abs_next;
    rec.signed_max = smax_next;
    rec.count      = count_next;
    rec.number     = number_next;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      run_sum  <= sum_next;
      run_max  <= max_next;
      run_abs  <= abs_next;
      run_smax <= smax_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voxel_counter   <= '0;
      cluster_counter <= '0;
    end else if (accept) begin
      voxel_counter <= rec_write ? '0 : count_next;
      if (rec_write) begin
        cluster_counter <= last_of_array ? '0 : number_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/clstat_queue.sv =====
// Short record queue between the front end and the back end.
// Holds finished cluster records; uses clstat_pkg for the record type.
`default_nettype none

`include "cluster_statistic_reducer_core_defines.svh"

module clstat_queue import clstat_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   wr_en,
  input  wire cluster_rec_t wr_data,
  input  wire logic   rd_en,
  output cluster_rec_t rd_data,
  output logic        full,
  output logic        empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W_Q-1:0] FULL_CNT = CNT_W_Q'(DEPTH);

  cluster_rec_t        slots [DEPTH];
  logic [PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [CNT_W_Q-1:0]  fill;

  assign full    = (fill == FULL_CNT);
  assign empty   = (fill == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  `CLSTAT_ASSERT(a_q_no_overflow, !(wr_en && full), "record queue written while full")
  `CLSTAT_ASSERT(a_q_no_underflow, !(rd_en && empty), "record queue read while empty")
  `CLSTAT_ASSERT_NEXT(a_q_fill_tracks, wr_en && !rd_en, fill == $past(fill) + 1'b1,
    "queue fill did not grow on write")

endmodule

`default_nettype wire

// ===== rtl/clstat_back.sv =====
// Back end: turns a cluster record into the selected statistic.
// Serial restoring divider for the mean, registered multiply for size.
// Uses clstat_pkg; holds the result register seen on the output side.
`default_nettype none

`include "cluster_statistic_reducer_core_defines.svh"

module clstat_back import clstat_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire cluster_rec_t q_data,
  input  wire logic        q_empty,
  output logic             q_pop,
  input  wire logic        res_pop,
  output logic             res_valid,
  output logic [MAG_W-1:0] res_value,
  output logic [CNT_W-1:0] res_count,
  output logic [NUM_W-1:0] res_number
);

  localparam int unsigned STEP_W = $clog2(SUM_W);
  localparam int unsigned REM_W  = CNT_W - 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  back_state_t st, st_next;

  logic                    sum_neg;
  logic [SUM_W-1:0]        quo;
  logic [REM_W-1:0]        rem;
  logic [STEP_W-1:0]       step;
  logic signed [MAG_W-1:0] max_r, smax_r;
  logic [MAG_W-1:0]        abs_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [NUM_W-1:0]        num_r;
  logic [PROD_W-1:0]       prod;

  logic             out_load;
  logic [SUM_W-1:0] sum_abs;
  logic [CNT_W-1:0] rem_shift;
  logic             rem_ge;
  logic [MAG_W-1:0] value;
  logic             pop_fire;

  assign pop_fire = res_pop && res_valid;

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      BK_IDLE: begin
        if (!q_empty) st_next = (cfg.edit_mode == MODE_MEAN) ? BK_DIV : BK_MUL;
      end
      BK_DIV:  if (step == LAST_STEP) st_next = BK_DONE;
      BK_MUL:  st_next = BK_DONE;
      BK_DONE: if (!res_valid || pop_fire) st_next = BK_IDLE;
      default: st_next = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    unique case (st)
      BK_IDLE: q_pop = !q_empty;
      BK_DIV:  ;
      BK_MUL:  ;
      BK_DONE: out_load = !res_valid || pop_fire;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= BK_IDLE;
    else     st <= st_next;
  end

  always_comb begin
    sum_abs   = q_data.sum[SUM_W-1] ? (~q_data.sum + 1'b1) : q_data.sum;
    rem_shift = {rem, quo[SUM_W-1]};
    rem_ge    = (rem_shift >= cnt_r);
  end

  // datapath: dividend shifts out of quo as quotient bits shift in
  always_ff @(posedge clk) begin
    if (q_pop) begin
      sum_neg <= q_data.sum[SUM_W-1];
      quo     <= sum_abs;
      rem     <= '0;
      step    <= '0;
      max_r   <= q_data.max_val;
      abs_r   <= q_data.abs_max;
      smax_r  <= q_data.signed_max;
      cnt_r   <= q_data.count;
      num_r   <= q_data.number;
    end else if (st == BK_DIV) begin
      rem  <= rem_ge ? REM_W'(rem_shift - cnt_r) : REM_W'(rem_shift);
      quo  <= {quo[SUM_W-2:0], rem_ge};
      step <= step + 1'b1;
    end
    if (st == BK_MUL) prod <= cnt_r * cfg.volume_scale;
  end

  always_comb begin
    case (cfg.edit_mode)
      MODE_MEAN: begin
        if (sum_neg) value = (quo > {{(SUM_W-MAG_W){1'b0}}, Q_MIN}) ? Q_MIN
                                                                  : ~quo[MAG_W-1:0] + 1'b1;
        else         value = (quo > {{(SUM_W-MAG_W){1'b0}}, Q_MAX}) ? Q_MAX : quo[MAG_W-1:0];
      end
      MODE_MAX:        value = max_r;
      MODE_ABS_MAX:    value = abs_r[MAG_W-1] ? Q_MAX : abs_r;
      MODE_SIGNED_MAX: value = smax_r;
      MODE_SIZE:       value = (prod > {{(PROD_W-MAG_W){1'b0}}, Q_MAX}) ? Q_MAX
                                                                       : prod[MAG_W-1:0];
      MODE_ORDER:      value = num_r[NUM_W-1] ? Q_MAX : {num_r[NUM_W-2:0], 16'h0000};
      default:         value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_value  <= value;
      res_count  <= cnt_r;
      res_number <= num_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)           res_valid <= 1'b0;
    else if (out_load) res_valid <= 1'b1;
    else if (pop_fire) res_valid <= 1'b0;
  end

  `CLSTAT_ASSERT(a_div_rem_below_divisor, st != BK_DIV || CNT_W'(rem) < cnt_r,
    "divider remainder not below divisor")
  `CLSTAT_ASSERT(a_div_nonzero, st != BK_DIV || cnt_r != '0, "mean division by zero count")
  `CLSTAT_ASSERT_NEXT(a_res_held, res_valid && !res_pop, res_valid && $stable(res_value),
    "stalled result changed")

endmodule

`default_nettype wire

// ===== rtl/cluster_statistic_reducer_core.sv =====
// Top level of the cluster statistic reducer: config registers, front end,
// record queue and back end. Uses clstat_pkg, clstat_front, clstat_queue, clstat_back.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------------
//   voxels   | push / full        | magnitude, last_of_cluster, last_of_array
//   results  | empty / pop        | cluster_value, voxel_count, cluster_number
//   config   | cfg_write          | cfg_index, cfg_data
//
// The front end takes one voxel beat per cycle while full is low; full rises
// only while the record queue holds QUEUE_DEPTH finished clusters.
// Per cluster the back end pops a record, runs a 48-step serial divider in mean mode
// or a registered multiply otherwise; write-back waits for a free output register.
// One result waits in the output register while the back end works on the next.
// rst is synchronous: counters and queue clear, registers return to their defaults.
`default_nettype none

module cluster_statistic_reducer_core import clstat_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic signed [MAG_W-1:0]   magnitude,
  input  wire logic                      last_of_cluster,
  input  wire logic                      last_of_array,
  output logic                           empty,
  input  wire logic                      pop,
  output logic signed [MAG_W-1:0]        cluster_value,
  output logic [CNT_W-1:0]               voxel_count,
  output logic [NUM_W-1:0]               cluster_number,
  input  wire logic                      cfg_write,
  input  wire logic                      cfg_index,
  input  wire logic [SCALE_W-1:0]        cfg_data
);

  cfg_t         cfg;
  cluster_rec_t rec_in, rec_out;
  logic         accept, rec_write, q_full, q_empty, q_pop, res_valid;
  logic [MAG_W-1:0] res_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edit_mode    <= MODE_MEAN;
      cfg.volume_scale <= SCALE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_EDIT_MODE:    cfg.edit_mode    <= cfg_data[MODE_W-1:0];
        REG_VOLUME_SCALE: cfg.volume_scale <= cfg_data;
        default:          ;
      endcase
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  clstat_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .magnitude       (magnitude),
    .last_of_cluster (last_of_cluster),
    .last_of_array   (last_of_array),
    .rec_write       (rec_write),
    .rec             (rec_in)
  );

  clstat_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_write),
    .wr_data (rec_in),
    .rd_en   (q_pop),
    .rd_data (rec_out),
    .full    (q_full),
    .empty   (q_empty)
  );

  clstat_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_data     (rec_out),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .res_pop    (pop),
    .res_valid  (res_valid),
    .res_value  (res_value),
    .res_count  (voxel_count),
    .res_number (cluster_number)
  );

  assign empty         = !res_valid;
  assign cluster_value = res_value;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for cluster_statistic_reducer_core: streams voxels cluster by cluster
// and checks one statistic beat per cluster. Depends on clstat_pkg and the block's RTL.

module testbench;
  import clstat_pkg::*;

  localparam int MODE_CODES    = 1 << MODE_W;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_VOXELS  = 140;
  localparam int REPORT_LIMIT  = 100;
  localparam int MAX_GAP       = 7;

  localparam longint VALUE_HI = 2147483647;
  localparam longint VALUE_LO = -VALUE_HI - 1;

  typedef struct {
    logic signed [MAG_W-1:0] value;
    logic        [CNT_W-1:0] count;
    logic        [NUM_W-1:0] number;
  } cluster_stat_t;

  // Predicts the per-cluster statistic and checks each result beat in order.
  class cluster_stat_board;
    logic [MODE_W-1:0]       edit_mode;
    logic [SCALE_W-1:0]      volume_scale;
    logic signed [SUM_W-1:0] sum;
    logic signed [MAG_W-1:0] max_val;
    logic signed [MAG_W-1:0] signed_max;
    logic [MAG_W:0]          abs_max;
    logic [CNT_W-1:0]        voxels;
    logic [NUM_W-1:0]        number;
    cluster_stat_t           pending[$];
    int                      errors;
    int                      results;

    function new();
      edit_mode    = MODE_MEAN;
      volume_scale = SCALE_RESET;
      sum          = '0;
      max_val      = '0;
      signed_max   = '0;
      abs_max      = '0;
      voxels       = '0;
      number       = '0;
      errors       = 0;
      results      = 0;
    endfunction

    function void set_register(reg_index_t idx, logic [SCALE_W-1:0] data);
      if (idx == REG_EDIT_MODE) begin
        edit_mode = data[MODE_W-1:0];
      end else begin
        volume_scale = data;
      end
    endfunction

    function logic [MAG_W:0] abs_of(logic signed [MAG_W-1:0] v);
      logic signed [MAG_W:0] wide;
      wide = v;
      return (wide < 0) ? -wide : wide;
    endfunction

    function void note_voxel(logic signed [MAG_W-1:0] mag, logic closes_cluster,
                             logic closes_array);
      cluster_stat_t     stat;
      logic [MAG_W:0]    mag_abs;
      logic [PROD_W-1:0] size;
      logic [MAG_W-1:0]  ordinal;
      longint            mean;
      mag_abs = abs_of(mag);
      if (voxels == 0) begin
        sum        = mag;
        max_val    = mag;
        signed_max = mag;
        abs_max    = mag_abs;
        voxels     = 1;
      end else if (voxels < MAX_CLUSTER_VOXELS) begin
        sum = sum + mag;
        if (mag > max_val) max_val = mag;
        if (mag_abs > abs_max) abs_max = mag_abs;
        // first voxel of strictly larger magnitude wins, ties keep the older one
        if (mag_abs > abs_of(signed_max)) signed_max = mag;
        voxels++;
      end
      if (!closes_cluster) return;
      if (number < MAX_CLUSTERS) number++;
      stat.count  = voxels;
      stat.number = number;
      case (edit_mode)
        MODE_MEAN: begin
          mean = longint'(sum) / longint'(voxels);
          if (mean > VALUE_HI) mean = VALUE_HI;
          if (mean < VALUE_LO) mean = VALUE_LO;
          stat.value = mean[MAG_W-1:0];
        end
        MODE_MAX:        stat.value = max_val;
        MODE_ABS_MAX:    stat.value = (abs_max > Q_MAX) ? Q_MAX : abs_max[MAG_W-1:0];
        MODE_SIGNED_MAX: stat.value = signed_max;
        MODE_SIZE: begin
          size       = voxels * volume_scale;
          stat.value = (size > Q_MAX) ? Q_MAX : size[MAG_W-1:0];
        end
        MODE_ORDER: begin
          ordinal    = {number, {(MAG_W-NUM_W){1'b0}}};
          stat.value = (ordinal > Q_MAX) ? Q_MAX : ordinal;
        end
        default: stat.value = '0;
      endcase
      pending.push_back(stat);
      sum        = '0;
      max_val    = '0;
      signed_max = '0;
      abs_max    = '0;
      voxels     = '0;
      if (closes_array) number = '0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%s", msg);
      if (errors == REPORT_LIMIT) $display("further mismatches are counted, not shown");
    endfunction

    function void check_result(logic signed [MAG_W-1:0] value, logic [CNT_W-1:0] count,
                               logic [NUM_W-1:0] num);
      cluster_stat_t want;
      results++;
      if (pending.size() == 0) begin
        flag($sformatf("%0t: result beat with no cluster pending: value %0d count %0d number %0d",
                       $time, value, count, num));
        return;
      end
      want = pending.pop_front();
      if (value !== want.value)
        flag($sformatf("%0t: cluster_value expected %0d, got %0d", $time, want.value, value));
      if (count !== want.count)
        flag($sformatf("%0t: voxel_count expected %0d, got %0d", $time, want.count, count));
      if (num !== want.number)
        flag($sformatf("%0t: cluster_number expected %0d, got %0d", $time, want.number, num));
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    push = 1'b0;
  logic                    full;
  logic signed [MAG_W-1:0] magnitude = '0;
  logic                    last_of_cluster = 1'b0;
  logic                    last_of_array = 1'b0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic signed [MAG_W-1:0] cluster_value;
  logic [CNT_W-1:0]        voxel_count;
  logic [NUM_W-1:0]        cluster_number;
  logic                    cfg_write = 1'b0;
  logic                    cfg_index = 1'b0;
  logic [SCALE_W-1:0]      cfg_data = '0;

  cluster_stat_board board = new();
  bit send_idling = 1'b1;
  bit take_idling = 1'b1;
  int voxels_sent = 0;
  int reg_writes  = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cluster_statistic_reducer_core i_dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .magnitude       (magnitude),
    .last_of_cluster (last_of_cluster),
    .last_of_array   (last_of_array),
    .empty           (empty),
    .pop             (pop),
    .cluster_value   (cluster_value),
    .voxel_count     (voxel_count),
    .cluster_number  (cluster_number),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  function automatic logic signed [MAG_W-1:0] draw_magnitude();
    case ($urandom_range(0, 7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return $urandom_range(0, 511) - 256;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_voxel(input logic signed [MAG_W-1:0] mag, input logic closes_cluster,
                            input logic closes_array);
    int gap;
    gap = send_idling ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push            <= 1'b1;
    magnitude       <= mag;
    last_of_cluster <= closes_cluster;
    last_of_array   <= closes_array;
    do @(posedge clk); while (full !== 1'b0);
    board.note_voxel(mag, closes_cluster, closes_array);
    voxels_sent++;
  endtask

  // all results out, then let any back-end work on a cluster finish
  task automatic settle();
    push <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [SCALE_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.set_register(idx, data);
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic run_random_phase(input int count);
    int   left;
    int   len;
    int   k;
    logic closing;
    logic ends_array;
    left = count;
    while (left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      for (k = 1; k <= len && left > 0; k++) begin
        closing = (k == len);
        // a stray array flag mid-cluster must be ignored
        ends_array = closing ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 15) == 0);
        send_voxel(draw_magnitude(), closing, ends_array);
        left--;
      end
    end
  endtask

  initial begin : result_taker
    int gap;
    wait (rst == 1'b0);
    forever begin
      gap = take_idling ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      board.check_result(cluster_value, voxel_count, cluster_number);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && full === 1'b0) || (pop && empty === 1'b0)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int                 m;
    int                 p;
    logic [SCALE_W-1:0] scale;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Each cluster opens under the previous mode and closes under the next one.
    // The middle voxel carries an array flag without a cluster end.
    for (m = 0; m < MODE_CODES; m++) begin
      send_voxel(-7, 1'b0, 1'b0);
      settle();
      write_reg(REG_EDIT_MODE, m);
      send_voxel(7, 1'b0, 1'b1);
      send_voxel((m == MODE_SIGNED_MAX) ? 3 : ((m > MODE_SIGNED_MAX) ? Q_MAX : Q_MIN),
                 1'b1, m == MODE_SIGNED_MAX);
    end

    for (p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      send_idling = (p % 3 != 1);
      take_idling = (p % 4 != 3);
      if (p < MODE_CODES) begin
        write_reg(REG_EDIT_MODE, p);
      end else if (p < MODE_CODES + 2) begin
        write_reg(REG_EDIT_MODE, MODE_SIZE);
      end else begin
        write_reg(REG_EDIT_MODE, $urandom_range(0, MODE_CODES - 1));
      end
      if (p == MODE_SIZE) scale = '0;
      else if (p == MODE_CODES) scale = '1;
      else if (p == MODE_CODES + 1) scale = $urandom_range(1, 8);
      else if (p % 2 == 0) scale = $urandom_range(0, 1 << 18);
      else scale = $urandom;
      write_reg(REG_VOLUME_SCALE, scale);
      run_random_phase(PHASE_VOXELS);
    end

    // close whatever cluster the last phase left open
    send_voxel(draw_magnitude(), 1'b1, 1'b1);

    settle();
    $display("Run covered %0d voxels, %0d cluster results and %0d register writes,",
             voxels_sent, board.results, reg_writes);
    $display("all eight mode codes, mid-cluster mode changes and stray array flags.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== cluster_statistic_reducer_core.f =====
+incdir+rtl
rtl/clstat_pkg.sv
rtl/clstat_front.sv
rtl/clstat_queue.sv
rtl/clstat_back.sv
rtl/cluster_statistic_reducer_core.sv
test/testbench.sv
